// ----- hw/rtl/positional_list_insert_delete_assert.svh -----
// assertion macros for the positional list checker
// depends on nothing; taken in by the checker file
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PLID_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plid assertion failed");

// next-cycle implication, disabled during reset
`define PLID_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plid assertion failed");

`endif

// ----- hw/rtl/plid_pkg.sv -----
// shared types and constants for the positional list block
// no dependencies
package plid_pkg;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;
   localparam int SIZE_W   = 6;
   localparam int STATUS_W = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_NOMATCH = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_STREAM
   } state_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_INSERT,
      ACT_DELETE,
      ACT_ROTATE
   } cell_act_type;

   typedef struct packed {
      cell_act_type             act;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- hw/rtl/plid_if.sv -----
// valid/ready channel interfaces for request and response transactions
// depends on plid_pkg
interface plid_req_if;
   import plid_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic signed [DATA_W-1:0] item_value;
   logic [POS_W-1:0]         position;
   modport source (output valid, opcode, item_value, position, input ready);
   modport sink (input valid, opcode, item_value, position, output ready);
endinterface

interface plid_rsp_if;
   import plid_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [SIZE_W-1:0]        list_size;
   logic [POS_W-1:0]         entry_index;
   logic signed [DATA_W-1:0] entry_value;
   logic                     list_empty;
   logic                     last_entry;
   modport source (output valid, status, list_size, entry_index, entry_value,
                   list_empty, last_entry, input ready);
   modport sink (input valid, status, list_size, entry_index, entry_value,
                 list_empty, last_entry, output ready);
endinterface

// ----- hw/rtl/plid_cell.sv -----
// one list slot: holds a value, loads the new item or zero, and moves values to or from its neighbors or the head
// depends on plid_pkg
module plid_cell #(
   parameter int INDEX = 0,
   parameter int CMPW  = 6
) (
   input  logic                               clock,
   input  plid_pkg::cell_cmd_type             cmd,
   input  logic [CMPW-1:0]                    pos,
   input  logic [CMPW-1:0]                    count,
   input  logic signed [plid_pkg::DATA_W-1:0] left_value,
   input  logic signed [plid_pkg::DATA_W-1:0] right_value,
   input  logic signed [plid_pkg::DATA_W-1:0] head_value,
   output logic signed [plid_pkg::DATA_W-1:0] cell_value,
   output logic                               match
);
   import plid_pkg::*;

   localparam logic [CMPW-1:0] MY_IDX  = CMPW'(INDEX);
   localparam logic [CMPW-1:0] NXT_IDX = CMPW'(INDEX + 1);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.act)
         ACT_INSERT: begin
            if (MY_IDX == pos) begin
               value_in = cmd.value;
            end else if (pos < count) begin
               // shift up inside the list
               if (MY_IDX > pos && MY_IDX <= count) value_in = left_value;
            end else begin
               // zero fill the gap past the old end
               if (MY_IDX >= count && MY_IDX < pos) value_in = '0;
            end
         end
         ACT_DELETE: begin
            if (MY_IDX >= pos && NXT_IDX < count) value_in = right_value;
         end
         ACT_ROTATE: begin
            // rotate within the used part so the list returns home after count steps
            if (NXT_IDX == count) value_in = head_value;
            else if (NXT_IDX < count) value_in = right_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;
   assign match      = (MY_IDX == pos) && (value_ff == cmd.value);

endmodule

// ----- hw/rtl/positional_list_insert_delete.sv -----
// after the request transaction the block steps through S_UPDATE into S_STREAM, then
// gives one result per cycle while the response side does not stall, one per entry
// and a single one for an empty list, as the stream walks the cell chain one slot each.
// a new request is taken only after the last result of the previous one.
// reset (synchronous) clears the entry count and control; slot values are not cleared.
module positional_list_insert_delete #(
   parameter int DEPTH = 32
) (
   input logic  clock,
   input logic  reset,
   plid_req_if.sink   req_if,
   plid_rsp_if.source rsp_if
);
   import plid_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            k_ff, k_in;
   op_type                   op_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [POS_W-1:0]         pos_ff;
   status_type               status_ff, status_in;

   cell_cmd_type             cmd;
   logic [CMPW-1:0]          pos_x, cnt_x;
   logic signed [DATA_W-1:0] cell_value [DEPTH];
   logic signed [DATA_W-1:0] left_v [DEPTH];
   logic signed [DATA_W-1:0] right_v [DEPTH];
   logic [DEPTH-1:0]         match_v;
   logic                     hit;
   logic                     req_fire, rsp_fire, is_last, is_empty;

   assign pos_x    = CMPW'(pos_ff);
   assign cnt_x    = CMPW'(count_ff);
   assign hit      = |match_v;
   assign is_empty = (count_ff == '0);
   assign is_last  = is_empty || (CW'(k_ff + 1'b1) == count_ff);
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_fire) state_in = S_UPDATE;
         S_UPDATE: state_in = S_STREAM;
         S_STREAM: if (rsp_fire && is_last) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;
      cmd.act      = ACT_HOLD;
      cmd.value    = val_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      k_in         = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
         end
         S_UPDATE: begin
            k_in      = '0;
            status_in = ST_DONE;
            if (op_ff == OP_INSERT) begin
               if (pos_x >= cnt_x) begin
                  if (pos_x >= DEPTH_X) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.act  = ACT_INSERT;
                     count_in = CW'(pos_x + CMPW'(1));
                  end
               end else if (cnt_x >= DEPTH_X) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.act  = ACT_INSERT;
                  count_in = CW'(count_ff + 1'b1);
               end
            end else begin
               if (pos_x < cnt_x && hit) begin
                  cmd.act  = ACT_DELETE;
                  count_in = CW'(count_ff - 1'b1);
               end else begin
                  status_in = ST_NOMATCH;
               end
            end
         end
         S_STREAM: begin
            rsp_if.valid = 1'b1;
            if (rsp_fire) begin
               cmd.act = ACT_ROTATE;
               k_in    = CW'(k_ff + 1'b1);
            end
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (req_fire) begin
         op_ff  <= op_type'(req_if.opcode);
         val_ff <= req_if.item_value;
         pos_ff <= req_if.position;
      end
   end

   // chain of slots, each wired to its neighbors; the two end slots see zero past the edge
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_v[g] = '0;
      end else begin : g_mid_l
         assign left_v[g] = cell_value[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_v[g] = '0;
      end else begin : g_mid_r
         assign right_v[g] = cell_value[g+1];
      end

      plid_cell #(
         .INDEX (g),
         .CMPW  (CMPW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (pos_x),
         .count       (cnt_x),
         .left_value  (left_v[g]),
         .right_value (right_v[g]),
         .head_value  (cell_value[0]),
         .cell_value  (cell_value[g]),
         .match       (match_v[g])
      );
   end

   assign rsp_if.status      = status_ff;
   assign rsp_if.list_size   = SIZE_W'(count_ff);
   assign rsp_if.entry_index = POS_W'(k_ff);
   assign rsp_if.entry_value = is_empty ? '0 : cell_value[0];
   assign rsp_if.list_empty  = is_empty;
   assign rsp_if.last_entry  = is_last;

endmodule

// ----- hw/rtl/plid_checker.sv -----
// port-level assertions for the positional list block, bound to the top level
// depends on plid_pkg and the assertion macro header
`include "positional_list_insert_delete_assert.svh"

module plid_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [plid_pkg::SIZE_W-1:0]        rsp_list_size,
   input logic [plid_pkg::POS_W-1:0]         rsp_entry_index,
   input logic signed [plid_pkg::DATA_W-1:0] rsp_entry_value,
   input logic                               rsp_list_empty,
   input logic                               rsp_last_entry
);
   import plid_pkg::*;

   // one transaction in flight: no request taken while results are offered
   `PLID_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready)

   // an empty list is a single closing result of size zero
   `PLID_ASSERT_NOW(a_empty_last, clock, reset, rsp_valid && rsp_list_empty,
                    rsp_last_entry && rsp_list_size == '0 && rsp_entry_index == '0)

   // a stream continues with the next index
   `PLID_ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && rsp_ready && !rsp_last_entry,
                     rsp_valid && rsp_entry_index == POS_W'($past(rsp_entry_index) + 1'b1))

   // the stream ends after the last result
   `PLID_ASSERT_NEXT(a_end_stream, clock, reset, rsp_valid && rsp_ready && rsp_last_entry,
                     !rsp_valid)

   // a stalled result holds
   `PLID_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_entry_value) && $stable(rsp_entry_index))

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_list_size   (rsp_if.list_size),
   .rsp_entry_index (rsp_if.entry_index),
   .rsp_entry_value (rsp_if.entry_value),
   .rsp_list_empty  (rsp_if.list_empty),
   .rsp_last_entry  (rsp_if.last_entry)
);
